// File: rtl/tcsf_pkg.sv
// shared types and constants of the triggered cubic slew follower
package tcsf_pkg;

  localparam int DATA_W       = 16;
  localparam int STEP_SHIFT   = 6;
  localparam int STEP_DIVISOR = 1 << STEP_SHIFT;
  localparam int MAG_W        = DATA_W;
  localparam int Q_W          = MAG_W - STEP_SHIFT;
  localparam int SQ_W         = 2 * Q_W;
  localparam int CUBE_W       = 3 * Q_W;

  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^32
  localparam int          RECIP_W     = 31;
  localparam logic [30:0] RECIP_100   = 31'd1374389535;
  localparam int          RECIP_SHIFT = 37;
  localparam int          PROD_W      = CUBE_W + RECIP_W;
  localparam int          QUO_W       = CUBE_W - 6;
  localparam int          STEP_W      = QUO_W + 2;
  localparam int          DIST_W      = DATA_W + 1;

  localparam logic signed [DATA_W-1:0] RESET_LEVEL      = -16'sd3200;
  localparam logic signed [DATA_W-1:0] TRIG_LOW_RESET   = -16'sd3200;
  localparam logic signed [DATA_W-1:0] TRIG_HIGH_RESET  = 16'sd3200;

  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIG_ENABLE = 2'd0,
    CFG_TRIG_LOW    = 2'd1,
    CFG_TRIG_HIGH   = 2'd2
  } cfg_index_t;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic [Q_W-1:0]           q;
    logic                     held;
  } entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CUBE,
    B_DIV,
    B_UPD
  } back_state_t;

endpackage

// File: rtl/tcsf_front.sv
// front end: trigger window registers, window check and step magnitude
module tcsf_front
  import tcsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic signed [DATA_W-1:0] target_value,
  input  logic signed [DATA_W-1:0] step_value,
  input  logic signed [DATA_W-1:0] trigger_value,
  output entry_t                   entry
);

  logic                     trig_enable;
  logic signed [DATA_W-1:0] trig_low;
  logic signed [DATA_W-1:0] trig_high;
  logic [MAG_W-1:0]         mag;
  logic                     held;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_enable <= 1'b0;
      trig_low    <= TRIG_LOW_RESET;
      trig_high   <= TRIG_HIGH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TRIG_ENABLE: trig_enable <= cfg_data[0];
        CFG_TRIG_LOW:    trig_low    <= signed'(cfg_data);
        CFG_TRIG_HIGH:   trig_high   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    held = 1'b0;
    if (trig_enable) begin
      if (trig_low <= trig_high) begin
        held = (trigger_value < trig_low) || (trigger_value > trig_high);
      end else begin
        held = (trigger_value < trig_low) && (trigger_value > trig_high);
      end
    end
    // magnitude of the most negative code is still exact as unsigned
    mag = step_value[DATA_W-1] ? MAG_W'(-step_value) : MAG_W'(step_value);
    entry.target = target_value;
    entry.q      = Q_W'(mag >> STEP_SHIFT);
    entry.held   = held;
  end

endmodule

// File: rtl/tcsf_fifo.sv
// short queue of classified items between front and back
module tcsf_fifo
  import tcsf_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output entry_t head,
  output logic   empty
);

  entry_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_CW-1:0]   count;

  assign full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tcsf_back.sv
// back end: cubic step sequencer, level update and result register
module tcsf_back
  import tcsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  entry_t                   head,
  input  logic                     empty,
  output logic                     pop,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] follower_value,
  output logic                     moved_enabled
);

  back_state_t              state;
  back_state_t              state_next;
  logic signed [DATA_W-1:0] target;
  logic [Q_W-1:0]           q;
  logic                     held;
  logic [SQ_W-1:0]          sq;
  logic [CUBE_W-1:0]        cube;
  logic [QUO_W-1:0]         quo;
  logic signed [DATA_W-1:0] level;
  logic [PROD_W-1:0]        prod;
  logic [STEP_W-1:0]        step;
  logic signed [DIST_W-1:0] diff;
  logic [DIST_W-1:0]        adist;
  logic signed [DATA_W-1:0] level_next;
  logic                     out_free;
  logic                     load;

  assign out_free = !result_valid || !result_stall;
  assign prod     = PROD_W'(cube) * PROD_W'(RECIP_100);
  assign step     = (STEP_W'(quo) << 1) + STEP_W'(quo);

  always_comb begin
    diff  = DIST_W'(target) - DIST_W'(level);
    adist = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);
    level_next = level;
    if (!held) begin
      if (STEP_W'(adist) < step) begin
        level_next = target;
      end else if (diff > 0) begin
        // step is at most the distance here, so no overshoot
        level_next = DATA_W'(DIST_W'(level) + step[DIST_W-1:0]);
      end else if (diff < 0) begin
        level_next = DATA_W'(DIST_W'(level) - step[DIST_W-1:0]);
      end
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load       = 1'b0;
    case (state)
      B_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = B_CUBE;
        end
      end
      B_CUBE: state_next = B_DIV;
      B_DIV:  state_next = B_UPD;
      B_UPD: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      target <= head.target;
      q      <= head.q;
      held   <= head.held;
      sq     <= SQ_W'(head.q) * SQ_W'(head.q);
    end
    if (state == B_CUBE) begin
      cube <= CUBE_W'(sq) * CUBE_W'(q);
    end
    if (state == B_DIV) begin
      quo <= prod[RECIP_SHIFT +: QUO_W];
    end
    if (load) begin
      follower_value <= level_next;
      moved_enabled  <= !held;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= RESET_LEVEL;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        level        <= level_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/triggered_cubic_slew_follower.sv
// top level of the triggered cubic slew follower
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  item     | item_valid/stall     | target_value, step_value, trigger_value
//  result   | result_valid/stall   | follower_value, moved_enabled
//  config   | cfg_valid/ready      | cfg_index, cfg_data
//
// the back end takes an item through square, cube, divide by 100 through
// a reciprocal multiply, then the level update into the result register
// the front accepts a beat whenever the two-entry queue has room, so up to two
// items wait while the back end works or the result is stalled
// synchronous reset clears the queue, the sequencer and the result valid, loads the
// level and the trigger window registers with reset values; cfg_ready is always high
module triggered_cubic_slew_follower
  import tcsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // item channel
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic signed [DATA_W-1:0] target_value,
  input  logic signed [DATA_W-1:0] step_value,
  input  logic signed [DATA_W-1:0] trigger_value,
  // result channel
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [DATA_W-1:0] follower_value,
  output logic                     moved_enabled,
  // config channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  entry_t front_entry;
  entry_t head;
  logic   full;
  logic   empty;
  logic   push;
  logic   pop;

  // register writes never wait
  assign cfg_ready  = 1'b1;
  // queue full is the only thing that holds off an item beat
  assign item_stall = full;
  assign push       = item_valid && !full;

  // window check and step magnitude happen on the way into the queue
  tcsf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .target_value  (target_value),
    .step_value    (step_value),
    .trigger_value (trigger_value),
    .entry         (front_entry)
  );

  tcsf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (front_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .empty      (empty)
  );

  // step law and level update; result register parts it from the sink
  tcsf_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .follower_value (follower_value),
    .moved_enabled  (moved_enabled)
  );

endmodule
